// File: rtl/savs_pkg.sv
package savs_pkg;

    localparam logic [3:0] CMD_PUSH  = 4'd0;
    localparam logic [3:0] CMD_PUSHV = 4'd1;
    localparam logic [3:0] CMD_POP   = 4'd2;
    localparam logic [3:0] CMD_DROP  = 4'd3;
    localparam logic [3:0] CMD_PEEK  = 4'd4;
    localparam logic [3:0] CMD_DUP   = 4'd5;
    localparam logic [3:0] CMD_ADD   = 4'd6;
    localparam logic [3:0] CMD_SUB   = 4'd7;
    localparam logic [3:0] CMD_DIV   = 4'd8;
    localparam logic [3:0] CMD_MUL   = 4'd9;
    localparam logic [3:0] CMD_EQ    = 4'd10;
    localparam logic [3:0] CMD_GT    = 4'd11;
    localparam logic [3:0] CMD_RDTOP = 4'd12;
    localparam logic [3:0] CMD_CLR   = 4'd13;

    localparam logic [2:0] ERR_OK   = 3'd0;
    localparam logic [2:0] ERR_VAR  = 3'd1;
    localparam logic [2:0] ERR_UND  = 3'd2;
    localparam logic [2:0] ERR_OVF  = 3'd3;
    localparam logic [2:0] ERR_DIV0 = 3'd4;

    typedef struct packed {
        logic start;
        logic div;
    } md_req_t;

endpackage

// File: rtl/savs_muldiv.sv
module savs_muldiv import savs_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  md_req_t               req,
    input  logic [DATA_WIDTH-1:0] a,
    input  logic [DATA_WIDTH-1:0] b,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] result
);

    localparam int DW = DATA_WIDTH;
    localparam int CW = $clog2(DW);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic          div_reg;
    logic          neg_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW:0]   acc_reg, acc_next;
    logic [DW-1:0] x_reg, x_next;
    logic [DW-1:0] y_reg;
    logic [DW-1:0] res_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic [DW-1:0] qfin;

    // one quotient bit or one partial product per cycle
    always_comb begin
        trial  = {acc_reg[DW-1:0], x_reg[DW-1]};
        diff   = trial - {1'b0, y_reg};
        qfin   = {x_reg[DW-2:0], ~diff[DW]};
        if (div_reg) begin
            acc_next = diff[DW] ? trial : diff;
            x_next   = qfin;
        end else begin
            acc_next = {1'b0, acc_reg[DW-1:0] + (y_reg[0] ? x_reg : '0)};
            x_next   = {x_reg[DW-2:0], 1'b0};
        end
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            busy_next = 1'b1;
        end else if (busy_reg && cnt_reg == CW'(DW - 1)) begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            div_reg <= req.div;
            cnt_reg <= '0;
            acc_reg <= '0;
            if (req.div) begin
                neg_reg <= a[DW-1] ^ b[DW-1];
                x_reg   <= a[DW-1] ? -a : a;
                y_reg   <= b[DW-1] ? -b : b;
            end else begin
                neg_reg <= 1'b0;
                x_reg   <= a;
                y_reg   <= b;
            end
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            acc_reg <= acc_next;
            x_reg   <= x_next;
            y_reg   <= div_reg ? y_reg : {1'b0, y_reg[DW-1:1]};
            if (cnt_reg == CW'(DW - 1)) begin
                if (div_reg) begin
                    res_reg <= neg_reg ? -qfin : qfin;
                end else begin
                    res_reg <= acc_next[DW-1:0];
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !req.start) else $error("muldiv restarted while busy");
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg)) else $error("done without work");
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg) else $error("done while busy");

endmodule

// File: rtl/stack_alu_with_variable_store.sv
// Stack ALU with a variable store. One command per request, one result per
// request. Plain commands read the stack memory and variable memory, decode
// and write back; add and sub likewise. Multiply and divide run in a shared
// shift-and-add / restoring divide unit between decode and write back. A
// request is taken only once the last one is written back. A stalled output
// holds the next request in write back. The stack top is cached in a
// register; the entry below it comes from the stack memory. A new request is
// taken while a result still waits on the output.
module stack_alu_with_variable_store import savs_pkg::*; #(
    parameter int STACK_DEPTH = 64,
    parameter int VAR_COUNT   = 16,
    parameter int DATA_WIDTH  = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // cmd[3:0], value[35:4], var_index[39:36]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // top_value, compare_flag, depth_now, error_code, pad
);

    localparam int DW  = DATA_WIDTH;
    localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int VW  = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EX   = 2'd1;
    localparam logic [1:0] ST_MD   = 2'd2;
    localparam logic [1:0] ST_WB   = 2'd3;

    logic [DW-1:0]  stk_mem [STACK_DEPTH];
    logic [DW-1:0]  var_mem [VAR_COUNT];
    logic [DW-1:0]  stk_rd_reg;
    logic [DW-1:0]  var_rd_reg;

    logic [1:0]     state_reg, state_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [DW-1:0]  top_reg, top_next;
    logic [VAR_COUNT-1:0] vld_reg, vld_next;
    logic [3:0]     cmd_reg;
    logic [DW-1:0]  val_reg;
    logic [3:0]     vi_reg;
    logic           m_valid_reg;
    logic [47:0]    m_data_reg;

    logic           in_fire;
    logic           wb_fire;
    logic [3:0]     in_cmd;
    logic [31:0]    in_value;
    logic [3:0]     in_vi;
    logic [VW-1:0]  vi_idx;
    logic           vok;
    logic           vvalid;
    logic           full;
    logic [2:0]     err;
    logic           flag;
    logic           do_push;
    logic           do_pop;
    logic           do_vwr;
    logic [DW-1:0]  push_val;
    logic [DW-1:0]  nxt;
    md_req_t        md_req;
    logic           md_done;
    logic [DW-1:0]  md_res;

    assign in_cmd   = s_tdata[3:0];
    assign in_value = s_tdata[35:4];
    assign in_vi    = s_tdata[39:36];
    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign wb_fire  = (state_reg == ST_WB) && (!m_valid_reg || m_tready);

    assign vi_idx = VW'(vi_reg);
    assign vok    = 32'(vi_reg) < VAR_COUNT;
    assign vvalid = vok && vld_reg[vi_idx];
    assign full   = (sp_reg == SPW'(STACK_DEPTH));
    assign nxt    = stk_rd_reg;

    always_comb begin
        err      = ERR_OK;
        flag     = 1'b0;
        do_push  = 1'b0;
        do_pop   = 1'b0;
        do_vwr   = 1'b0;
        push_val = val_reg;
        case (cmd_reg)
            CMD_PUSH: begin
                if (full) err = ERR_OVF;
                else do_push = 1'b1;
            end
            CMD_PUSHV: begin
                push_val = var_rd_reg;
                if (!vvalid) err = ERR_VAR;
                else if (full) err = ERR_OVF;
                else do_push = 1'b1;
            end
            CMD_POP, CMD_PEEK: begin
                if (!vok) err = ERR_VAR;
                else if (sp_reg == '0) err = ERR_UND;
                else begin
                    do_vwr = 1'b1;
                    do_pop = (cmd_reg == CMD_POP);
                end
            end
            CMD_DROP: begin
                if (sp_reg == '0) err = ERR_UND;
                else do_pop = 1'b1;
            end
            CMD_RDTOP: begin
                if (sp_reg == '0) err = ERR_UND;
            end
            CMD_DUP: begin
                push_val = top_reg;
                if (sp_reg == '0) err = ERR_UND;
                else if (full) err = ERR_OVF;
                else do_push = 1'b1;
            end
            CMD_ADD, CMD_SUB, CMD_DIV, CMD_MUL: begin
                if (cmd_reg == CMD_ADD) push_val = top_reg + nxt;
                else if (cmd_reg == CMD_SUB) push_val = top_reg - nxt;
                else push_val = md_res;
                if (sp_reg < SPW'(2)) err = ERR_UND;
                else if (full) err = ERR_OVF;
                else if (cmd_reg == CMD_DIV && nxt == '0) err = ERR_DIV0;
                else do_push = 1'b1;
            end
            CMD_EQ, CMD_GT: begin
                if (sp_reg < SPW'(2)) err = ERR_UND;
                else if (cmd_reg == CMD_EQ) flag = (top_reg == nxt);
                else flag = ($signed(top_reg) > $signed(nxt));
            end
            default: begin
            end
        endcase
    end

    assign md_req.start = (state_reg == ST_EX) && (err == ERR_OK) &&
                          (cmd_reg == CMD_DIV || cmd_reg == CMD_MUL);
    assign md_req.div   = (cmd_reg == CMD_DIV);

    savs_muldiv #(.DATA_WIDTH(DW)) u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (md_req),
        .a       (top_reg),
        .b       (nxt),
        .done    (md_done),
        .result  (md_res)
    );

    always_comb begin
        state_next = state_reg;
        sp_next    = sp_reg;
        top_next   = top_reg;
        vld_next   = vld_reg;
        case (state_reg)
            ST_IDLE: if (in_fire) state_next = ST_EX;
            ST_EX:   state_next = md_req.start ? ST_MD : ST_WB;
            ST_MD:   if (md_done) state_next = ST_WB;
            ST_WB: begin
                if (wb_fire) begin
                    state_next = ST_IDLE;
                    if (do_push) begin
                        sp_next  = sp_reg + 1'b1;
                        top_next = push_val;
                    end
                    if (do_pop) begin
                        sp_next  = sp_reg - 1'b1;
                        top_next = nxt;
                    end
                    if (do_vwr) vld_next[vi_idx] = 1'b1;
                    if (cmd_reg == CMD_CLR) begin
                        sp_next  = '0;
                        vld_next = '0;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            sp_reg      <= '0;
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            vld_reg   <= vld_next;
            if (wb_fire) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg <= top_next;
        if (in_fire) begin
            cmd_reg <= in_cmd;
            val_reg <= DW'($signed(in_value));
            vi_reg  <= in_vi;
        end
        if (wb_fire) begin
            m_data_reg[31:0]  <= (sp_next == '0) ? 32'd0 : 32'($signed(top_next));
            m_data_reg[32]    <= flag;
            m_data_reg[39:33] <= 7'(sp_next);
            m_data_reg[42:40] <= err;
            m_data_reg[47:43] <= '0;
        end
    end

    // stack memory: read entry below top on request, write on push
    always_ff @(posedge aclk) begin
        if (wb_fire && do_push) stk_mem[AW'(sp_reg)] <= push_val;
        if (in_fire) stk_rd_reg <= stk_mem[AW'(sp_reg - SPW'(2))];
    end

    // variable memory
    always_ff @(posedge aclk) begin
        if (wb_fire && do_vwr) var_mem[vi_idx] <= top_reg;
        if (in_fire) var_rd_reg <= var_mem[VW'(in_vi)];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_sp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SPW'(STACK_DEPTH)) else $error("stack pointer out of range");
    a_err_keeps_sp: assert property (@(posedge aclk) disable iff (!aresetn)
        wb_fire && err != ERR_OK |=> sp_reg == $past(sp_reg))
        else $error("stack changed on error");
    a_md_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MD && !md_done |=> state_reg == ST_MD)
        else $error("left multiply/divide wait early");
    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        wb_fire |=> state_reg == ST_IDLE && m_valid_reg)
        else $error("result not posted");

endmodule

// File: tb/sv/stack_alu_with_variable_store_tb.sv
`timescale 1ns / 1ps

module stack_alu_with_variable_store_tb;
    import savs_pkg::*;

    localparam logic [3:0] CMD_SPARE0 = 4'd14;
    localparam logic [3:0] CMD_SPARE1 = 4'd15;
    localparam int DEPTH_MAX = 64;
    localparam int RANDOM_REQUESTS = 1525;
    localparam int QUIET_TAIL = 200;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [31:0] MOST_NEG = 32'h8000_0000;
    localparam logic [31:0] MOST_POS = 32'h7fff_ffff;

    typedef struct packed {
        logic [31:0] top;
        logic        flag;
        logic [6:0]  depth;
        logic [2:0]  err;
    } alu_result_t;

    typedef struct {
        logic [3:0]  cmd;
        logic [31:0] value;
        logic [3:0]  slot;
        bit          known;
        alu_result_t res;
    } cmd_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // cmd, value, var_index
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // top_value, compare_flag, depth_now, error_code

    logic [31:0] stack_mem [DEPTH_MAX];
    int          stack_ptr;
    logic [31:0] var_mem [16];
    bit          var_ok [16];

    alu_result_t pending_results [$];
    cmd_row_t    directed_rows [$];
    int          mismatches;
    int          cycles;
    int          stall_left;
    bit          quiet;

    stack_alu_with_variable_store dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic alu_result_t run_command(logic [3:0] cmd, logic [31:0] value,
                                                logic [3:0] slot);
        alu_result_t r;
        logic [31:0] top;
        logic [31:0] nxt;
        logic [31:0] acc;
        r = '0;
        top = (stack_ptr >= 1) ? stack_mem[stack_ptr - 1] : '0;
        nxt = (stack_ptr >= 2) ? stack_mem[stack_ptr - 2] : '0;
        case (cmd)
            CMD_PUSH: begin
                if (stack_ptr >= DEPTH_MAX) r.err = ERR_OVF;
                else begin
                    stack_mem[stack_ptr] = value;
                    stack_ptr++;
                end
            end
            CMD_PUSHV: begin
                if (!var_ok[slot]) r.err = ERR_VAR;
                else if (stack_ptr >= DEPTH_MAX) r.err = ERR_OVF;
                else begin
                    stack_mem[stack_ptr] = var_mem[slot];
                    stack_ptr++;
                end
            end
            CMD_POP, CMD_PEEK: begin
                if (stack_ptr < 1) r.err = ERR_UND;
                else begin
                    var_mem[slot] = top;
                    var_ok[slot] = 1'b1;
                    if (cmd == CMD_POP) stack_ptr--;
                end
            end
            CMD_DROP: begin
                if (stack_ptr < 1) r.err = ERR_UND;
                else stack_ptr--;
            end
            CMD_DUP: begin
                if (stack_ptr < 1) r.err = ERR_UND;
                else if (stack_ptr >= DEPTH_MAX) r.err = ERR_OVF;
                else begin
                    stack_mem[stack_ptr] = top;
                    stack_ptr++;
                end
            end
            CMD_ADD, CMD_SUB, CMD_DIV, CMD_MUL: begin
                if (stack_ptr < 2) r.err = ERR_UND;
                else if (stack_ptr >= DEPTH_MAX) r.err = ERR_OVF;
                else if (cmd == CMD_DIV && nxt == '0) r.err = ERR_DIV0;
                else begin
                    case (cmd)
                        CMD_ADD: acc = top + nxt;
                        CMD_SUB: acc = top - nxt;
                        CMD_MUL: acc = top * nxt;
                        default: begin
                            if (top == MOST_NEG && nxt == '1) acc = MOST_NEG;
                            else acc = $signed(top) / $signed(nxt);
                        end
                    endcase
                    stack_mem[stack_ptr] = acc;
                    stack_ptr++;
                end
            end
            CMD_EQ, CMD_GT: begin
                if (stack_ptr < 2) r.err = ERR_UND;
                else if (cmd == CMD_EQ) r.flag = (top == nxt);
                else r.flag = ($signed(top) > $signed(nxt));
            end
            CMD_RDTOP: begin
                if (stack_ptr < 1) r.err = ERR_UND;
            end
            CMD_CLR: begin
                stack_ptr = 0;
                foreach (var_ok[i]) var_ok[i] = 1'b0;
            end
            default: ;
        endcase
        r.top = (stack_ptr >= 1) ? stack_mem[stack_ptr - 1] : '0;
        r.depth = stack_ptr[6:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %0s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
        mismatches++;
    endtask

    task automatic send_request(logic [3:0] cmd, logic [31:0] value, logic [3:0] slot,
                                bit known, alu_result_t fixed_res);
        alu_result_t r;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {slot, value, cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = run_command(cmd, value, slot);
        pending_results.push_back(known ? fixed_res : r);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return MOST_NEG;
            1: return MOST_POS;
            2: return '0;
            3: return '1;
            4: return 32'd1;
            5, 6: return $urandom_range(0, 40) - 20;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [3:0] pick_command(int mode);
        int roll;
        roll = $urandom_range(0, 99);
        if (mode == 0) begin
            if (roll < 40) return CMD_PUSH;
            if (roll < 55) return CMD_DUP;
            if (roll < 65) return CMD_PUSHV;
        end else if (mode == 1) begin
            if (roll < 30) return CMD_DROP;
            if (roll < 55) return CMD_POP;
        end
        return 4'($urandom_range(0, 15));
    endfunction

    task automatic add_row(logic [3:0] cmd, logic [31:0] value, logic [3:0] slot,
                           bit known, logic [31:0] top, logic [6:0] depth,
                           logic [2:0] err);
        cmd_row_t row;
        row.cmd = cmd;
        row.value = value;
        row.slot = slot;
        row.known = known;
        row.res = '{top: top, flag: 1'b0, depth: depth, err: err};
        directed_rows.push_back(row);
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 15) == 0) begin
            stall_left <= $urandom_range(0, 18);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        alu_result_t got;
        alu_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[31:0], m_tdata[32], m_tdata[39:33], m_tdata[42:40]};
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", got.top, '0);
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (got.top !== want.top) report_mismatch("top_value", got.top, want.top);
                if (got.flag !== want.flag)
                    report_mismatch("compare_flag", 32'(got.flag), 32'(want.flag));
                if (got.depth !== want.depth)
                    report_mismatch("depth_now", 32'(got.depth), 32'(want.depth));
                if (got.err !== want.err)
                    report_mismatch("error_code", 32'(got.err), 32'(want.err));
            end
        end
    end

    initial begin
        int mode;
        int waited;
        logic [3:0] cmd;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        mismatches = 0;
        cycles = 0;
        quiet = 1'b0;
        stack_ptr = 0;
        foreach (var_ok[i]) var_ok[i] = 1'b0;

        add_row(CMD_DROP, '0, 4'd0, 1, '0, 7'd0, ERR_UND);
        add_row(CMD_ADD, '0, 4'd0, 1, '0, 7'd0, ERR_UND);
        add_row(CMD_PUSHV, '0, 4'd3, 1, '0, 7'd0, ERR_VAR);
        add_row(CMD_PUSH, MOST_POS, 4'd0, 1, MOST_POS, 7'd1, ERR_OK);
        add_row(CMD_PUSH, MOST_NEG, 4'd0, 1, MOST_NEG, 7'd2, ERR_OK);
        add_row(CMD_ADD, '0, 4'd0, 0, '0, '0, '0);
        add_row(CMD_SUB, '0, 4'd0, 0, '0, '0, '0);
        add_row(CMD_GT, '0, 4'd0, 0, '0, '0, '0);
        add_row(CMD_PUSH, '1, 4'd0, 1, '1, 7'd5, ERR_OK);
        add_row(CMD_PUSH, MOST_NEG, 4'd0, 1, MOST_NEG, 7'd6, ERR_OK);
        add_row(CMD_DIV, '0, 4'd0, 0, '0, '0, '0);
        add_row(CMD_MUL, '0, 4'd0, 0, '0, '0, '0);
        add_row(CMD_PUSH, '0, 4'd0, 1, '0, 7'd9, ERR_OK);
        add_row(CMD_PUSH, 32'd5, 4'd0, 1, 32'd5, 7'd10, ERR_OK);
        add_row(CMD_DIV, '0, 4'd0, 1, 32'd5, 7'd10, ERR_DIV0);
        add_row(CMD_DUP, '0, 4'd0, 0, '0, '0, '0);
        add_row(CMD_EQ, '0, 4'd0, 0, '0, '0, '0);
        add_row(CMD_POP, '0, 4'd15, 0, '0, '0, '0);
        add_row(CMD_PEEK, '0, 4'd0, 0, '0, '0, '0);
        add_row(CMD_PUSHV, '0, 4'd15, 0, '0, '0, '0);
        add_row(CMD_RDTOP, '0, 4'd0, 0, '0, '0, '0);
        add_row(CMD_SPARE0, '1, 4'd15, 0, '0, '0, '0);
        add_row(CMD_SPARE1, '0, 4'd0, 0, '0, '0, '0);
        add_row(CMD_CLR, '0, 4'd0, 1, '0, 7'd0, ERR_OK);
        add_row(CMD_PUSHV, '0, 4'd15, 1, '0, 7'd0, ERR_VAR);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].cmd, directed_rows[i].value,
                         directed_rows[i].slot, directed_rows[i].known,
                         directed_rows[i].res);

        mode = 2;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 90 == 0) mode = $urandom_range(0, 2);
            if (n == RANDOM_REQUESTS / 2) begin
                s_tvalid <= 1'b0;
                while (pending_results.size() != 0) @(posedge aclk);
            end
            if (n == RANDOM_REQUESTS - QUIET_TAIL) quiet = 1'b1;
            cmd = pick_command(mode);
            send_request(cmd, pick_value(), 4'($urandom_range(0, 15)), 0, '0);
        end
        s_tvalid <= 1'b0;

        waited = 0;
        while (pending_results.size() != 0 && waited < 100000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (60) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
